>>> rtl/stis_pkg.sv
// ----------------------------------------------------------------------------
// stis_pkg
// Shared types and codes for the sorted insertion table.
// ----------------------------------------------------------------------------
package stis_pkg;

    // request operation
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // field widths of a result word
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;
    localparam int VALUE_W = 64;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified request as it sits in the queue
    typedef struct packed {
        t_op                  op;
        logic [VALUE_W-1:0]   value;
    } t_req;

endpackage

>>> rtl/stis_in_if.sv
// ----------------------------------------------------------------------------
// stis_in_if
// Request channel: valid/ready with func and value.
// ----------------------------------------------------------------------------
interface stis_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

>>> rtl/stis_out_if.sv
// ----------------------------------------------------------------------------
// stis_out_if
// Result channel: valid/ready with status, position, count and sum.
// ----------------------------------------------------------------------------
interface stis_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  position;
    logic [6:0]  entry_count;
    logic [63:0] running_sum;

    modport source (output valid, output status, output position,
                    output entry_count, output running_sum, input ready);
    modport sink   (input valid, input status, input position,
                    input entry_count, input running_sum, output ready);
endinterface

>>> rtl/stis_ram.sv
// ----------------------------------------------------------------------------
// stis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/stis_front.sv
// ----------------------------------------------------------------------------
// stis_front
// Accepts request words, decodes the operation and queues them for the back.
// ----------------------------------------------------------------------------
module stis_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    stis_in_if.sink         i_in,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output stis_pkg::t_req  o_q_req
);

    localparam int QAW = $clog2(stis_pkg::QUEUE_DEPTH);
    localparam int QCW = $clog2(stis_pkg::QUEUE_DEPTH + 1);

    stis_pkg::t_req r_slot [stis_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wptr, n_wptr;
    logic [QAW-1:0] r_rptr, n_rptr;
    logic [QCW-1:0] r_fill, n_fill;
    logic           push, pop;
    stis_pkg::t_req in_req;

    // decode incoming word
    always_comb begin
        in_req.op    = i_in.func ? stis_pkg::OP_LOOKUP : stis_pkg::OP_INSERT;
        in_req.value = i_in.value;
    end

    assign i_in.ready = (r_fill != QCW'(stis_pkg::QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_fill != '0);
    assign pop        = o_q_valid && i_q_ready;
    assign o_q_req    = r_slot[r_rptr];

    // pointer and fill update
    always_comb begin
        n_wptr = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = pop  ? r_rptr + 1'b1 : r_rptr;
        n_fill = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
        if (push) begin
            r_slot[r_wptr] <= in_req;
        end
    end

endmodule

>>> rtl/stis_back.sv
// ----------------------------------------------------------------------------
// stis_back
// Executes queued requests against the sorted table and drives results.
// ----------------------------------------------------------------------------
module stis_back #(
    parameter int CAPACITY = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  stis_pkg::t_req  i_q_req,
    stis_out_if.source      o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_PUT,
        S_OUT
    } t_state;

    t_state                           r_state, n_state;
    stis_pkg::t_req                   r_req, n_req;
    logic [AW-1:0]                    r_idx, n_idx;
    logic [AW-1:0]                    r_raddr, n_raddr;
    logic [CW-1:0]                    r_count, n_count;
    logic [stis_pkg::VALUE_W-1:0]     r_sum, n_sum;
    logic [1:0]                       r_res_status, n_res_status;
    logic [stis_pkg::POS_W-1:0]       r_res_pos, n_res_pos;
    logic                             r_ovalid, n_ovalid;
    logic [1:0]                       r_ostatus, n_ostatus;
    logic [stis_pkg::POS_W-1:0]       r_opos, n_opos;
    logic [stis_pkg::COUNT_W-1:0]     r_ocount, n_ocount;
    logic [stis_pkg::VALUE_W-1:0]     r_osum, n_osum;

    logic                             we;
    logic [AW-1:0]                    waddr;
    logic [stis_pkg::VALUE_W-1:0]     wdata;
    logic [stis_pkg::VALUE_W-1:0]     rdata;

    stis_ram #(
        .WIDTH (stis_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_raddr),
        .o_rdata (rdata)
    );

    assign o_q_ready = (r_state == S_IDLE);

    // sequencer: inserts shift from the top down, lookups scan from the bottom
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_raddr      = r_raddr;
        n_count      = r_count;
        n_sum        = r_sum;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_ovalid     = r_ovalid;
        n_ostatus    = r_ostatus;
        n_opos       = r_opos;
        n_ocount     = r_ocount;
        n_osum       = r_osum;
        we           = 1'b0;
        waddr        = r_idx;
        wdata        = r_req.value;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_req     = i_q_req;
                    n_res_pos = '0;
                    if (i_q_req.op == stis_pkg::OP_INSERT) begin
                        n_res_status = stis_pkg::ST_OK;
                        if (r_count == CAP_C) begin
                            n_res_status = stis_pkg::ST_FULL;
                            n_state      = S_OUT;
                        end else if (r_count == '0) begin
                            we      = 1'b1;
                            waddr   = '0;
                            wdata   = i_q_req.value;
                            n_count = r_count + 1'b1;
                            n_sum   = r_sum + i_q_req.value;
                            n_state = S_OUT;
                        end else begin
                            n_idx   = r_count[AW-1:0];
                            n_raddr = r_count[AW-1:0] - 1'b1;
                            n_state = S_RD;
                        end
                    end else begin
                        n_res_status = stis_pkg::ST_NOT_FOUND;
                        if (r_count == '0) begin
                            n_state = S_OUT;
                        end else begin
                            n_idx   = '0;
                            n_raddr = '0;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                // RAM captures the address this cycle
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_req.op == stis_pkg::OP_INSERT) begin
                    if (rdata > r_req.value) begin
                        // move the larger entry up one place
                        we    = 1'b1;
                        waddr = r_idx;
                        wdata = rdata;
                        n_idx = r_idx - 1'b1;
                        if (r_idx == AW'(1)) begin
                            n_state = S_PUT;
                        end else begin
                            n_raddr = r_idx - AW'(2);
                            n_state = S_RD;
                        end
                    end else begin
                        we      = 1'b1;
                        waddr   = r_idx;
                        wdata   = r_req.value;
                        n_count = r_count + 1'b1;
                        n_sum   = r_sum + r_req.value;
                        n_state = S_OUT;
                    end
                end else begin
                    if (rdata == r_req.value) begin
                        n_res_status = stis_pkg::ST_OK;
                        n_res_pos    = stis_pkg::POS_W'(r_idx);
                        n_state      = S_OUT;
                    end else if (rdata > r_req.value ||
                                 CW'(r_idx) + 1'b1 == r_count) begin
                        n_state = S_OUT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_raddr = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_PUT: begin
                // new value is the smallest: goes in at the bottom
                we      = 1'b1;
                waddr   = '0;
                wdata   = r_req.value;
                n_count = r_count + 1'b1;
                n_sum   = r_sum + r_req.value;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_res_status;
                    n_opos    = r_res_pos;
                    n_ocount  = stis_pkg::COUNT_W'(r_count);
                    n_osum    = r_sum;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_ovalid <= n_ovalid;
        end
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_raddr      <= n_raddr;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_ostatus    <= n_ostatus;
        r_opos       <= n_opos;
        r_ocount     <= n_ocount;
        r_osum       <= n_osum;
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_ostatus;
    assign o_out.position    = r_opos;
    assign o_out.entry_count = r_ocount;
    assign o_out.running_sum = r_osum;

endmodule

>>> rtl/sorted_table_insert_rank_sum_top.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_rank_sum_top
// Sorted table of 64-bit values with insert, lookup and running sum.
// ----------------------------------------------------------------------------
// Request words are queued two deep by the front end and executed one at a
// time by the back end against a single-port-read table RAM of CAPACITY
// entries. Every request returns one result word. An insert scans down from
// the top, moving each larger entry up one place, and writes its value in the
// gap, or at the bottom when it is smaller than every stored entry. A lookup
// scans up from the bottom until it hits, passes its value or ends the table.
// A full-table reject or a request on an empty table needs no scan. Each scan
// step is a registered RAM read and the compare behind it. The table needs no
// clearing after reset: only entries below the stored count are read.
module sorted_table_insert_rank_sum_top #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stis_in_if.sink     i_in,
    stis_out_if.source  o_out
);

    localparam logic [stis_pkg::COUNT_W-1:0] CAP_FIELD =
        stis_pkg::COUNT_W'(CAPACITY);

    logic           q_valid;
    logic           q_ready;
    stis_pkg::t_req q_req;

    stis_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_req   (q_req)
    );

    stis_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_req   (q_req),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    // only the three defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status == stis_pkg::ST_OK ||
                         o_out.status == stis_pkg::ST_NOT_FOUND ||
                         o_out.status == stis_pkg::ST_FULL))
        else $error("undefined result status");

    // position is zero on every result whose status is not OK
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != stis_pkg::ST_OK) |-> o_out.position == '0)
        else $error("non-zero position on miss or reject");

    // a full reject only happens with the table at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == stis_pkg::ST_FULL) |->
            o_out.entry_count == CAP_FIELD)
        else $error("full reject below capacity");
`endif

endmodule
